// ===== hdl/constrained_multi_queue_dispatcher_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the constrained multi-queue dispatcher
// Shorthand for clocked implications used by the port checker.
// ----------------------------------------------------------------------------
`ifndef CONSTRAINED_MULTI_QUEUE_DISPATCHER_TOP_MACROS_SVH
`define CONSTRAINED_MULTI_QUEUE_DISPATCHER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CMQD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define CMQD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/cmqd_pkg.sv =====
// ----------------------------------------------------------------------------
// Constrained multi-queue dispatcher package
// Codes, register layout and shared types of the dispatcher.
// ----------------------------------------------------------------------------
package cmqd_pkg;

   typedef enum logic [1:0] {
      MODE_SUBMIT   = 2'd0,
      MODE_FETCH    = 2'd1,
      MODE_COMPLETE = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      ST_ADDED      = 3'd0,
      ST_DROPPED    = 3'd1,
      ST_DISPATCHED = 3'd2,
      ST_NOTHING    = 3'd3,
      ST_COMPLETED  = 3'd4,
      ST_CERROR     = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      DM_CLEAN = 2'd0,
      DM_DIRTY = 2'd1,
      DM_ANY   = 2'd2,
      DM_FREE  = 2'd3
   } dirty_mode_type;

   // Register indexes on the configuration port.
   localparam int CSR_QUEUES_IN_USE         = 0;
   localparam int CSR_QUEUE_SETTINGS_FIRST  = 1;
   localparam int CSR_QUEUE_SETTINGS_COUNT  = 4;

   localparam int CSR_INDEX_W = 3;
   localparam int SETTINGS_W  = 20;
   localparam int QIU_W       = 3;
   localparam int TAG_W       = 16;
   localparam int ZOOM_W      = 5;
   localparam int QIDX_W      = 2;
   localparam int ACTIVE_W    = 8;

   localparam logic [QIU_W-1:0]      QUEUES_IN_USE_RESET = 3'd1;
   localparam logic [SETTINGS_W-1:0] SETTINGS_RESET      = 20'd19424;

   // Queue settings layout.
   localparam int MINZ_LSB  = 0;
   localparam int MAXZ_LSB  = 5;
   localparam int DMODE_LSB = 10;
   localparam int LIMIT_LSB = 12;

   typedef struct packed {
      mode_type            mode;
      logic [TAG_W-1:0]    request_tag;
      logic [ZOOM_W-1:0]   zoom;
      logic                is_dirty_request;
      logic [QIDX_W-1:0]   queue_index;
   } item_type;

   typedef struct packed {
      status_type          status;
      logic [QIDX_W-1:0]   chosen_queue;
      logic                dispatched;
   } decision_type;

endpackage

// ===== hdl/constrained_multi_queue_dispatcher_top.sv =====
// ----------------------------------------------------------------------------
// Constrained multi-queue dispatcher
// Keeps several filtered LIFO request queues with per-queue render limits.
// ----------------------------------------------------------------------------
// The dispatcher accepts one item per clock cycle while results are being
// taken, and each item is handled in steps once it is accepted: the
// item is registered, the queue decision and the count update happen in the
// next cycle together with the access to the tag stack memory, the registered
// read of that memory completes in the cycle after, and the finished result
// then sits in a four-entry result queue. The depth of that result queue sets
// how many items may be in flight, so req_tready drops only when four results
// are owed and the result side is stalled. A submit pushes the tag on the
// first enabled queue whose zoom range and dirty filter match and that is not
// full; a fetch pops the newest tag of the first enabled queue with pending
// work and a free render slot; a complete frees one render slot of the named
// queue. The tag stacks are not cleared after reset, which is safe because
// only entries below a queue's pending count are ever returned. Configuration
// writes are always taken and must only be issued while the block is idle.
// ----------------------------------------------------------------------------
module constrained_multi_queue_dispatcher_top #(
   parameter int NUM_QUEUES  = 4,
   parameter int QUEUE_DEPTH = 32,
   parameter int TAG_BITS    = 16
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // request_tag[15:0], zoom[20:16], queue_index[22:21]
   input  logic [2:0]  req_tuser,  // mode[1:0], is_dirty_request[2]
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // chosen_queue[1:0], dispatched_tag[17:2]
   output logic [2:0]  rsp_tuser,  // status[2:0]
   // Configuration write channel.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [19:0] csr_data
);

   localparam int QW        = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int IDX_W     = $clog2(QUEUE_DEPTH);
   localparam int AW        = QW + IDX_W;
   localparam int OUT_DEPTH = 4;
   localparam int OUT_CW    = $clog2(OUT_DEPTH+1);
   localparam int RES_W     = 3 + cmqd_pkg::QIDX_W + cmqd_pkg::TAG_W;

   logic                   req_accept;
   logic                   s1_valid_ff;
   cmqd_pkg::item_type     s1_item_ff, s1_item_in;
   logic                   s2_valid_ff;
   cmqd_pkg::decision_type s2_dec_ff, s1_dec;

   logic                   mem_we;
   logic [AW-1:0]          mem_waddr, mem_raddr;
   logic [TAG_BITS-1:0]    mem_wdata, mem_rdata;

   logic [31:0]            rd_wide;
   logic [15:0]            result_tag;
   logic [RES_W-1:0]       push_data, head_data;
   logic [OUT_CW-1:0]      out_count;
   logic [OUT_CW:0]        in_flight;

   // Items still owed a result slot: the two pipeline stages plus the queue.
   assign in_flight  = {1'b0, out_count} + (OUT_CW+1)'(s1_valid_ff)
                                         + (OUT_CW+1)'(s2_valid_ff);
   assign req_tready = (in_flight < (OUT_CW+1)'(OUT_DEPTH));
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_comb begin
      s1_item_in.mode             = cmqd_pkg::mode_type'(req_tuser[1:0]);
      s1_item_in.is_dirty_request = req_tuser[2];
      s1_item_in.request_tag      = req_tdata[15:0];
      s1_item_in.zoom             = req_tdata[20:16];
      s1_item_in.queue_index      = req_tdata[22:21];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_accept;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_item_ff <= s1_item_in;
      end
      s2_dec_ff <= s1_dec;
   end

   cmqd_sched #(
      .NUM_QUEUES  (NUM_QUEUES),
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .TAG_BITS    (TAG_BITS)
   ) u_sched (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .item_valid (s1_valid_ff),
      .item       (s1_item_ff),
      .decision   (s1_dec),
      .mem_we     (mem_we),
      .mem_waddr  (mem_waddr),
      .mem_wdata  (mem_wdata),
      .mem_raddr  (mem_raddr)
   );

   // Tag stacks: queue index in the upper address bits, stack slot below.
   cmqd_ram #(
      .WIDTH (TAG_BITS),
      .DEPTH (2**AW)
   ) u_tag_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // The read data belongs to the item now in the second stage.
   assign rd_wide    = 32'(mem_rdata);
   assign result_tag = s2_dec_ff.dispatched ? rd_wide[15:0] : 16'd0;
   assign push_data  = {s2_dec_ff.status, s2_dec_ff.chosen_queue, result_tag};

   cmqd_fifo #(
      .WIDTH (RES_W),
      .DEPTH (OUT_DEPTH)
   ) u_out_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (s2_valid_ff),
      .push_data  (push_data),
      .pop        (rsp_tready),
      .head_valid (rsp_tvalid),
      .head_data  (head_data),
      .count      (out_count)
   );

   assign rsp_tuser = head_data[RES_W-1 -: 3];
   assign rsp_tdata = {6'd0, head_data[15:0], head_data[17:16]};

endmodule

// ===== hdl/cmqd_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cmqd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/cmqd_fifo.sv =====
// ----------------------------------------------------------------------------
// Result queue
// Small register FIFO that holds finished results until they are taken.
// ----------------------------------------------------------------------------
module cmqd_fifo #(
   parameter int WIDTH = 21,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   input  logic                       pop,
   output logic                       head_valid,
   output logic [WIDTH-1:0]           head_data,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH+1);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_pop;

   assign do_pop = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_valid = (count_ff != '0);
   assign head_data  = data_ff[rd_ptr_ff];
   assign count      = count_ff;

endmodule

// ===== hdl/cmqd_sched.sv =====
// ----------------------------------------------------------------------------
// Dispatcher scheduler
// Holds the configuration and the per-queue counts, picks the queue for one
// item and drives the tag stack memory.
// ----------------------------------------------------------------------------
module cmqd_sched #(
   parameter int NUM_QUEUES  = 4,
   parameter int QUEUE_DEPTH = 32,
   parameter int TAG_BITS    = 16,
   localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1,
   localparam int IDX_W = $clog2(QUEUE_DEPTH),
   localparam int AW = QW + IDX_W
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write,
   input  logic [cmqd_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [cmqd_pkg::SETTINGS_W-1:0]        csr_data,
   input  logic                                   item_valid,
   input  cmqd_pkg::item_type                     item,
   output cmqd_pkg::decision_type                 decision,
   output logic                                   mem_we,
   output logic [AW-1:0]                          mem_waddr,
   output logic [TAG_BITS-1:0]                    mem_wdata,
   output logic [AW-1:0]                          mem_raddr
);

   localparam int CW = $clog2(QUEUE_DEPTH+1);

   logic [cmqd_pkg::QIU_W-1:0]      queues_in_use_ff;
   logic [cmqd_pkg::SETTINGS_W-1:0] settings_ff [NUM_QUEUES];
   logic [CW-1:0]                   pending_ff [NUM_QUEUES];
   logic [CW-1:0]                   pending_in [NUM_QUEUES];
   logic [cmqd_pkg::ACTIVE_W-1:0]   active_ff [NUM_QUEUES];
   logic [cmqd_pkg::ACTIVE_W-1:0]   active_in [NUM_QUEUES];

   logic [3:0]            n_enabled;
   logic [NUM_QUEUES-1:0] can_take;
   logic [NUM_QUEUES-1:0] can_serve;
   logic                  sub_hit, fet_hit, cpl_ok;
   logic [QW-1:0]         sub_q, fet_q, cpl_q;
   logic [CW-1:0]         top_idx;
   logic [31:0]           tag_wide;

   function automatic logic zoom_dirty_match(
      input logic [cmqd_pkg::SETTINGS_W-1:0] s,
      input logic [cmqd_pkg::ZOOM_W-1:0]     zoom,
      input logic                            dirty
   );
      logic [cmqd_pkg::ZOOM_W-1:0] minz;
      logic [cmqd_pkg::ZOOM_W-1:0] maxz;
      cmqd_pkg::dirty_mode_type    dm;
      logic                        ok;
      minz = s[cmqd_pkg::MINZ_LSB +: cmqd_pkg::ZOOM_W];
      maxz = s[cmqd_pkg::MAXZ_LSB +: cmqd_pkg::ZOOM_W];
      dm   = cmqd_pkg::dirty_mode_type'(s[cmqd_pkg::DMODE_LSB +: 2]);
      ok   = (zoom >= minz) && (zoom <= maxz);
      case (dm)
         cmqd_pkg::DM_CLEAN: ok = ok && !dirty;
         cmqd_pkg::DM_DIRTY: ok = ok && dirty;
         cmqd_pkg::DM_ANY:   ok = ok;
         cmqd_pkg::DM_FREE:  ok = 1'b1;
         default:            ok = 1'b0;
      endcase
      return ok;
   endfunction

   assign n_enabled = (4'(queues_in_use_ff) > 4'(NUM_QUEUES)) ? 4'(NUM_QUEUES)
                                                              : 4'(queues_in_use_ff);

   // Per-queue eligibility; every queue is evaluated side by side.
   always_comb begin
      for (int q = 0; q < NUM_QUEUES; q++) begin
         can_take[q]  = (4'(q) < n_enabled)
                     && (pending_ff[q] != CW'(QUEUE_DEPTH))
                     && zoom_dirty_match(settings_ff[q], item.zoom, item.is_dirty_request);
         can_serve[q] = (4'(q) < n_enabled)
                     && (pending_ff[q] != '0)
                     && (active_ff[q] <
                         settings_ff[q][cmqd_pkg::LIMIT_LSB +: cmqd_pkg::ACTIVE_W]);
      end
   end

   // Lowest-index winner of each search.
   always_comb begin
      sub_hit = 1'b0;
      sub_q   = '0;
      fet_hit = 1'b0;
      fet_q   = '0;
      for (int q = NUM_QUEUES - 1; q >= 0; q--) begin
         if (can_take[q]) begin
            sub_hit = 1'b1;
            sub_q   = QW'(q);
         end
         if (can_serve[q]) begin
            fet_hit = 1'b1;
            fet_q   = QW'(q);
         end
      end
   end

   assign cpl_q    = QW'(item.queue_index);
   assign cpl_ok   = (int'(item.queue_index) < NUM_QUEUES) && (active_ff[cpl_q] != '0);
   assign top_idx  = pending_ff[fet_q] - 1'b1;
   assign tag_wide = 32'(item.request_tag);

   always_comb begin
      pending_in = pending_ff;
      active_in  = active_ff;
      mem_we     = 1'b0;
      mem_waddr  = {sub_q, pending_ff[sub_q][IDX_W-1:0]};
      mem_wdata  = tag_wide[TAG_BITS-1:0];
      mem_raddr  = {fet_q, top_idx[IDX_W-1:0]};
      decision.status       = cmqd_pkg::ST_NOTHING;
      decision.chosen_queue = '0;
      decision.dispatched   = 1'b0;
      case (item.mode)
         cmqd_pkg::MODE_SUBMIT: begin
            if (sub_hit) begin
               decision.status       = cmqd_pkg::ST_ADDED;
               decision.chosen_queue = 2'(sub_q);
               mem_we                = item_valid;
               pending_in[sub_q]     = pending_ff[sub_q] + 1'b1;
            end else begin
               decision.status = cmqd_pkg::ST_DROPPED;
            end
         end
         cmqd_pkg::MODE_FETCH: begin
            if (fet_hit) begin
               decision.status       = cmqd_pkg::ST_DISPATCHED;
               decision.chosen_queue = 2'(fet_q);
               decision.dispatched   = 1'b1;
               pending_in[fet_q]     = top_idx;
               active_in[fet_q]      = active_ff[fet_q] + 1'b1;
            end
         end
         cmqd_pkg::MODE_COMPLETE: begin
            decision.chosen_queue = item.queue_index;
            if (cpl_ok) begin
               decision.status  = cmqd_pkg::ST_COMPLETED;
               active_in[cpl_q] = active_ff[cpl_q] - 1'b1;
            end else begin
               decision.status = cmqd_pkg::ST_CERROR;
            end
         end
         default: begin
            decision.status = cmqd_pkg::ST_NOTHING;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         queues_in_use_ff <= cmqd_pkg::QUEUES_IN_USE_RESET;
         for (int q = 0; q < NUM_QUEUES; q++) begin
            settings_ff[q] <= cmqd_pkg::SETTINGS_RESET;
            pending_ff[q]  <= '0;
            active_ff[q]   <= '0;
         end
      end else begin
         if (csr_write &&
             csr_index == cmqd_pkg::CSR_INDEX_W'(cmqd_pkg::CSR_QUEUES_IN_USE)) begin
            queues_in_use_ff <= csr_data[cmqd_pkg::QIU_W-1:0];
         end
         for (int q = 0; q < NUM_QUEUES; q++) begin
            if (csr_write && q < cmqd_pkg::CSR_QUEUE_SETTINGS_COUNT &&
                csr_index ==
                   cmqd_pkg::CSR_INDEX_W'(cmqd_pkg::CSR_QUEUE_SETTINGS_FIRST + q)) begin
               settings_ff[q] <= csr_data;
            end
         end
         if (item_valid) begin
            pending_ff <= pending_in;
            active_ff  <= active_in;
         end
      end
   end

endmodule

// ===== hdl/cmqd_checker.sv =====
// ----------------------------------------------------------------------------
// Dispatcher port checker
// Watches the result channel of the dispatcher and flags malformed results.
// ----------------------------------------------------------------------------
`include "constrained_multi_queue_dispatcher_top_macros.svh"

module cmqd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [2:0]  rsp_tuser
);

   `CMQD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "result withdrawn while stalled")
   `CMQD_ASSERT_IMPLY(a_status_range, clock, reset, rsp_tvalid, rsp_tuser <= cmqd_pkg::ST_CERROR, "status code out of range")
   `CMQD_ASSERT_IMPLY(a_tag_zero, clock, reset, rsp_tvalid && rsp_tuser != cmqd_pkg::ST_DISPATCHED, rsp_tdata[17:2] == 16'd0, "tag given without a dispatch")
   `CMQD_ASSERT_IMPLY(a_queue_zero, clock, reset, rsp_tvalid && (rsp_tuser == cmqd_pkg::ST_DROPPED || rsp_tuser == cmqd_pkg::ST_NOTHING), rsp_tdata[1:0] == 2'd0, "queue given without a match")

endmodule

bind constrained_multi_queue_dispatcher_top cmqd_checker u_checker (.*);

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the constrained multi-queue dispatcher
// Streams submit, fetch and complete items through the dispatcher and checks
// each result against a cycle-free model of the queues kept in the bench.
// ----------------------------------------------------------------------------
module tb;

   // Geometry of the block as instantiated.
   localparam int QUEUE_COUNT = 4;
   localparam int STACK_DEPTH = 32;

   // The fourth mode code is unused by the block and must be ignored.
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   // Register indexes past the end of the map; writes there are ignored.
   localparam int CSR_UNMAPPED_LOW  = cmqd_pkg::CSR_QUEUE_SETTINGS_FIRST +
                                      cmqd_pkg::CSR_QUEUE_SETTINGS_COUNT;
   localparam int CSR_UNMAPPED_HIGH = (1 << cmqd_pkg::CSR_INDEX_W) - 1;

   // Time after which the run is declared hung.
   localparam int RUN_LIMIT_NS = 2_000_000;

   // One result as the block reports it.
   typedef struct packed {
      cmqd_pkg::status_type        status;
      logic [cmqd_pkg::QIDX_W-1:0] chosen_queue;
      logic [cmqd_pkg::TAG_W-1:0]  dispatched_tag;
   } outcome_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;  // request_tag[15:0], zoom[20:16], queue_index[22:21]
   logic [2:0]  req_tuser  = '0;  // mode[1:0], is_dirty_request[2]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // chosen_queue[1:0], dispatched_tag[17:2]
   logic [2:0]  rsp_tuser;        // status[2:0]
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index  = '0;
   logic [19:0] csr_data   = '0;

   constrained_multi_queue_dispatcher_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // ------------------------------------------------------------------------
   // Bench copy of the dispatcher state. The configuration side is updated
   // when a register write completes; the queues move when an item is taken.
   // ------------------------------------------------------------------------
   logic [cmqd_pkg::QIU_W-1:0]      queues_enabled;
   logic [cmqd_pkg::SETTINGS_W-1:0] queue_cfg [QUEUE_COUNT];
   logic [cmqd_pkg::TAG_W-1:0]      tag_stack [QUEUE_COUNT][STACK_DEPTH];
   int                              pending_depth [QUEUE_COUNT];
   int                              renders_active [QUEUE_COUNT];

   // Items waiting to be offered, results owed by the block, and bookkeeping.
   cmqd_pkg::item_type request_items[$];
   outcome_type        expected_outcomes[$];
   cmqd_pkg::item_type offered_item;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   logic        rsp_hold      = 1'b0;
   int          stage         = 0;
   int          fail_count    = 0;
   int          items_taken   = 0;
   int          results_checked = 0;
   int          status_seen [6] = '{default: 0};

   function automatic void apply_register(input logic [2:0] index, input logic [19:0] value);
      if (index == cmqd_pkg::CSR_QUEUES_IN_USE) begin
         queues_enabled = value[cmqd_pkg::QIU_W-1:0];
      end else if (index >= cmqd_pkg::CSR_QUEUE_SETTINGS_FIRST &&
                   index < cmqd_pkg::CSR_QUEUE_SETTINGS_FIRST +
                           cmqd_pkg::CSR_QUEUE_SETTINGS_COUNT) begin
         queue_cfg[index - cmqd_pkg::CSR_QUEUE_SETTINGS_FIRST] = value;
      end
   endfunction

   // A submit fits a queue that has room and whose filters let it through.
   // The unconstrained dirty mode skips the zoom check as well.
   function automatic bit submit_fits(input int q, input logic [cmqd_pkg::ZOOM_W-1:0] zoom,
                                      input logic dirty);
      logic [cmqd_pkg::ZOOM_W-1:0] minz;
      logic [cmqd_pkg::ZOOM_W-1:0] maxz;
      cmqd_pkg::dirty_mode_type    filter;
      minz   = queue_cfg[q][cmqd_pkg::MINZ_LSB +: cmqd_pkg::ZOOM_W];
      maxz   = queue_cfg[q][cmqd_pkg::MAXZ_LSB +: cmqd_pkg::ZOOM_W];
      filter = cmqd_pkg::dirty_mode_type'(queue_cfg[q][cmqd_pkg::DMODE_LSB +: 2]);
      if (pending_depth[q] >= STACK_DEPTH) return 1'b0;
      if (filter == cmqd_pkg::DM_FREE) return 1'b1;
      if (zoom < minz || zoom > maxz) return 1'b0;
      if (filter == cmqd_pkg::DM_CLEAN && dirty) return 1'b0;
      if (filter == cmqd_pkg::DM_DIRTY && !dirty) return 1'b0;
      return 1'b1;
   endfunction

   // Works out the result of one item and moves the bench queues accordingly.
   function automatic outcome_type dispatch_decision(input cmqd_pkg::item_type it);
      outcome_type                   o;
      int                            searched;
      bit                            done;
      logic [cmqd_pkg::ACTIVE_W-1:0] limit;
      o.status         = cmqd_pkg::ST_NOTHING;
      o.chosen_queue   = '0;
      o.dispatched_tag = '0;
      done             = 1'b0;
      // A count above the number of queues simply enables all of them.
      searched = (queues_enabled > QUEUE_COUNT) ? QUEUE_COUNT : int'(queues_enabled);
      case (it.mode)
         cmqd_pkg::MODE_SUBMIT: begin
            o.status = cmqd_pkg::ST_DROPPED;
            for (int q = 0; q < searched; q++) begin
               if (!done && submit_fits(q, it.zoom, it.is_dirty_request)) begin
                  tag_stack[q][pending_depth[q]] = it.request_tag;
                  pending_depth[q]++;
                  o.status       = cmqd_pkg::ST_ADDED;
                  o.chosen_queue = cmqd_pkg::QIDX_W'(q);
                  done           = 1'b1;
               end
            end
         end
         cmqd_pkg::MODE_FETCH: begin
            // Only the first queue that can be served moves; newest tag first.
            for (int q = 0; q < searched; q++) begin
               limit = queue_cfg[q][cmqd_pkg::LIMIT_LSB +: cmqd_pkg::ACTIVE_W];
               if (!done && pending_depth[q] > 0 && renders_active[q] < limit) begin
                  pending_depth[q]--;
                  o.dispatched_tag = tag_stack[q][pending_depth[q]];
                  renders_active[q]++;
                  o.status       = cmqd_pkg::ST_DISPATCHED;
                  o.chosen_queue = cmqd_pkg::QIDX_W'(q);
                  done           = 1'b1;
               end
            end
         end
         cmqd_pkg::MODE_COMPLETE: begin
            // A disabled queue is freed like any other; an idle one is flagged.
            o.chosen_queue = it.queue_index;
            if (renders_active[it.queue_index] > 0) begin
               renders_active[it.queue_index]--;
               o.status = cmqd_pkg::ST_COMPLETED;
            end else begin
               o.status = cmqd_pkg::ST_CERROR;
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   // ------------------------------------------------------------------------
   // Clock and reset.
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Request driver. The expected result is computed at the edge where the
   // item is taken, then the next item (or a gap) is put on the bus.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_outcomes.push_back(dispatch_decision(offered_item));
            items_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (request_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               offered_item = request_items.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {1'b0, offered_item.queue_index, offered_item.zoom,
                              offered_item.request_tag};
               req_tuser  <= {offered_item.is_dirty_request, offered_item.mode};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result monitor. Every result taken is matched against the oldest owed
   // one, field by field; rsp_tready is then redrawn for the next edge.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_outcomes.size() == 0) begin
               $error("result with none owed: status %0d chosen_queue %0d tag %0h",
                      rsp_tuser, rsp_tdata[1:0], rsp_tdata[17:2]);
               fail_count++;
            end else begin
               want = expected_outcomes.pop_front();
               status_seen[want.status]++;
               if (rsp_tuser !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_tuser);
                  fail_count++;
               end
               if (rsp_tdata[1:0] !== want.chosen_queue) begin
                  $error("chosen_queue: expected %0d, got %0d",
                         want.chosen_queue, rsp_tdata[1:0]);
                  fail_count++;
               end
               if (rsp_tdata[17:2] !== want.dispatched_tag) begin
                  $error("dispatched_tag: expected %0h, got %0h",
                         want.dispatched_tag, rsp_tdata[17:2]);
                  fail_count++;
               end
            end
            results_checked++;
         end
         rsp_tready <= !rsp_hold && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // ------------------------------------------------------------------------
   // Back-pressure burst. Once the last stage is running with no idling, the
   // receiver stops for a long stretch while the sender keeps offering, so
   // the result queue fills and req_tready has to drop.
   // ------------------------------------------------------------------------
   initial begin
      wait (stage == 3);
      repeat (30) @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (250) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // Hang guard.
   initial begin
      #RUN_LIMIT_NS;
      $display("timeout: %0d items taken, %0d results checked", items_taken,
               results_checked);
      $display("status: fail");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers.
   // ------------------------------------------------------------------------
   task automatic push_item(input logic [1:0] mode, input logic [15:0] tag,
                            input logic [4:0] zoom, input logic dirty,
                            input logic [1:0] qidx);
      cmqd_pkg::item_type it;
      it.mode             = cmqd_pkg::mode_type'(mode);
      it.request_tag      = tag;
      it.zoom             = zoom;
      it.is_dirty_request = dirty;
      it.queue_index      = qidx;
      request_items.push_back(it);
   endtask

   // Registers may only change while nothing is in flight. Every item makes
   // exactly one result, so an empty list of owed results means idle.
   task automatic wait_until_drained();
      do @(negedge clock);
      while (request_items.size() != 0 || req_tvalid || expected_outcomes.size() != 0);
   endtask

   task automatic write_register(input logic [2:0] index, input logic [19:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      apply_register(index, value);
   endtask

   task automatic configure_queues(input logic [2:0] count, input logic [19:0] s0,
                                   input logic [19:0] s1, input logic [19:0] s2,
                                   input logic [19:0] s3);
      write_register(3'(cmqd_pkg::CSR_QUEUES_IN_USE), {17'd0, count});
      write_register(3'(cmqd_pkg::CSR_QUEUE_SETTINGS_FIRST),     s0);
      write_register(3'(cmqd_pkg::CSR_QUEUE_SETTINGS_FIRST + 1), s1);
      write_register(3'(cmqd_pkg::CSR_QUEUE_SETTINGS_FIRST + 2), s2);
      write_register(3'(cmqd_pkg::CSR_QUEUE_SETTINGS_FIRST + 3), s3);
   endtask

   function automatic logic [19:0] queue_settings(input int minz, input int maxz,
                                                  input cmqd_pkg::dirty_mode_type filter,
                                                  input int limit);
      return {8'(limit), 2'(filter), 5'(maxz), 5'(minz)};
   endfunction

   // Mostly wide zoom windows and small render limits, so queues both fill
   // and drain; now and then an empty window, a zero limit or the largest one.
   function automatic logic [19:0] random_queue_settings();
      int limit;
      limit = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(1, 6);
      return queue_settings($urandom_range(12), $urandom_range(8, 31),
                            cmqd_pkg::dirty_mode_type'($urandom_range(3)), limit);
   endfunction

   // Random items come in bursts that lean toward filling the queues, toward
   // draining them, or neither, so the stacks swing between empty and full.
   task automatic queue_random_items(input int count);
      int left;
      int burst;
      int lean;
      int pick;
      int submit_pct;
      int fetch_pct;
      logic [1:0] mode;
      left = count;
      while (left > 0) begin
         burst = $urandom_range(4, 40);
         lean  = $urandom_range(2);
         submit_pct = (lean == 0) ? 70 : (lean == 1) ? 20 : 45;
         fetch_pct  = (lean == 0) ? 15 : (lean == 1) ? 40 : 30;
         for (int i = 0; i < burst && left > 0; i++) begin
            pick = $urandom_range(99);
            if (pick < submit_pct)                  mode = cmqd_pkg::MODE_SUBMIT;
            else if (pick < submit_pct + fetch_pct) mode = cmqd_pkg::MODE_FETCH;
            else if (pick < 98)                     mode = cmqd_pkg::MODE_COMPLETE;
            else                                    mode = MODE_UNUSED;
            push_item(mode, 16'($urandom), 5'($urandom_range(31)), 1'($urandom_range(1)),
                      2'($urandom_range(3)));
            left--;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Main sequence.
   // ------------------------------------------------------------------------
   initial begin
      queues_enabled = cmqd_pkg::QUEUES_IN_USE_RESET;
      for (int q = 0; q < QUEUE_COUNT; q++) begin
         queue_cfg[q]      = cmqd_pkg::SETTINGS_RESET;
         pending_depth[q]  = 0;
         renders_active[q] = 0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed items, first with the reset configuration: one queue, any
      // zoom, any dirty state, four renders.
      stage         = 0;
      send_idle_pct = 38;
      recv_idle_pct = 68;
      push_item(cmqd_pkg::MODE_SUBMIT,   16'h0F0F, 5'd7, 1'b0, 2'd0);
      push_item(cmqd_pkg::MODE_FETCH,    16'h0000, 5'd0, 1'b0, 2'd0);
      push_item(cmqd_pkg::MODE_COMPLETE, 16'h0000, 5'd0, 1'b0, 2'd0);
      wait_until_drained();

      // One queue of each filter kind: clean only on a narrow window with one
      // render, dirty only with two, an empty window, and an unconstrained
      // queue with an empty window and no render slot at all.
      configure_queues(3'd4,
                       queue_settings(10, 20, cmqd_pkg::DM_CLEAN, 1),
                       queue_settings(0, 31, cmqd_pkg::DM_DIRTY, 2),
                       queue_settings(25, 5, cmqd_pkg::DM_ANY, 3),
                       queue_settings(31, 0, cmqd_pkg::DM_FREE, 0));
      push_item(cmqd_pkg::MODE_SUBMIT,   16'h0000, 5'd0,  1'b0, 2'd0);
      push_item(cmqd_pkg::MODE_SUBMIT,   16'hFFFF, 5'd31, 1'b1, 2'd3);
      push_item(cmqd_pkg::MODE_SUBMIT,   16'h1234, 5'd10, 1'b0, 2'd1);
      push_item(cmqd_pkg::MODE_SUBMIT,   16'h5678, 5'd20, 1'b1, 2'd2);
      push_item(cmqd_pkg::MODE_SUBMIT,   16'hAAAA, 5'd15, 1'b0, 2'd0);
      push_item(cmqd_pkg::MODE_FETCH,    16'h0000, 5'd0,  1'b0, 2'd0);
      push_item(cmqd_pkg::MODE_FETCH,    16'hFFFF, 5'd31, 1'b1, 2'd3);
      push_item(cmqd_pkg::MODE_FETCH,    16'h0000, 5'd0,  1'b0, 2'd0);
      push_item(cmqd_pkg::MODE_FETCH,    16'h0000, 5'd0,  1'b0, 2'd0);
      push_item(cmqd_pkg::MODE_COMPLETE, 16'h0000, 5'd0,  1'b0, 2'd0);
      push_item(cmqd_pkg::MODE_COMPLETE, 16'h0000, 5'd0,  1'b0, 2'd2);
      push_item(cmqd_pkg::MODE_FETCH,    16'h0000, 5'd0,  1'b0, 2'd0);
      push_item(MODE_UNUSED,             16'hFFFF, 5'd31, 1'b1, 2'd3);
      push_item(cmqd_pkg::MODE_COMPLETE, 16'h0000, 5'd0,  1'b0, 2'd3);
      push_item(cmqd_pkg::MODE_COMPLETE, 16'h0000, 5'd0,  1'b0, 2'd1);
      push_item(cmqd_pkg::MODE_COMPLETE, 16'h0000, 5'd0,  1'b0, 2'd1);
      push_item(cmqd_pkg::MODE_COMPLETE, 16'h0000, 5'd0,  1'b0, 2'd1);
      wait_until_drained();

      // No queue enabled: submits drop, fetches find nothing, but a complete
      // still frees a render on a disabled queue.
      write_register(3'(cmqd_pkg::CSR_QUEUES_IN_USE), 20'd0);
      push_item(cmqd_pkg::MODE_SUBMIT,   16'h00FF, 5'd12, 1'b0, 2'd0);
      push_item(cmqd_pkg::MODE_FETCH,    16'h0000, 5'd0,  1'b0, 2'd0);
      push_item(cmqd_pkg::MODE_COMPLETE, 16'h0000, 5'd0,  1'b0, 2'd0);
      wait_until_drained();

      // A count past the number of queues behaves as all of them.
      write_register(3'(cmqd_pkg::CSR_QUEUES_IN_USE), 20'd7);
      push_item(cmqd_pkg::MODE_SUBMIT, 16'hFF00, 5'd31, 1'b0, 2'd0);
      push_item(cmqd_pkg::MODE_FETCH,  16'h0000, 5'd0,  1'b0, 2'd0);
      wait_until_drained();

      // Random stage one: a catch-all queue behind a random one, and a queue
      // with every setting bit clear (zoom 0 only, clean, never served).
      stage = 1;
      configure_queues(3'd4, random_queue_settings(), 20'hFFFFF,
                       random_queue_settings(), 20'h00000);
      queue_random_items(500);
      wait_until_drained();

      // Random stage two: the receiver is the fast side now. Writes to the
      // unmapped indexes must leave everything as it was.
      stage         = 2;
      send_idle_pct = 68;
      recv_idle_pct = 38;
      configure_queues(3'd3, random_queue_settings(), random_queue_settings(),
                       random_queue_settings(), random_queue_settings());
      write_register(3'(CSR_UNMAPPED_LOW), 20'hFFFFF);
      write_register(3'(CSR_UNMAPPED_LOW + 1), 20'h00000);
      write_register(3'(CSR_UNMAPPED_HIGH), 20'hFFFFF);
      queue_random_items(500);
      wait_until_drained();

      // Random stage three: no idling on either side, apart from the long
      // receiver stop started by the back-pressure process.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      configure_queues(3'd7, cmqd_pkg::SETTINGS_RESET, random_queue_settings(),
                       random_queue_settings(), random_queue_settings());
      queue_random_items(500);
      stage = 3;
      wait_until_drained();

      // Anything the block sends after the last owed result is caught by the
      // monitor during this tail.
      repeat (20) @(posedge clock);
      $display("summary: %0d items, %0d results over three idling patterns and several configs",
               items_taken, results_checked);
      $display("summary: added %0d, dropped %0d, dispatched %0d, idle fetch %0d, completed %0d, complete errors %0d",
               status_seen[cmqd_pkg::ST_ADDED], status_seen[cmqd_pkg::ST_DROPPED],
               status_seen[cmqd_pkg::ST_DISPATCHED], status_seen[cmqd_pkg::ST_NOTHING],
               status_seen[cmqd_pkg::ST_COMPLETED], status_seen[cmqd_pkg::ST_CERROR]);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/cmqd_pkg.sv
hdl/cmqd_ram.sv
hdl/cmqd_fifo.sv
hdl/cmqd_sched.sv
hdl/constrained_multi_queue_dispatcher_top.sv
hdl/cmqd_checker.sv
bench/tb.sv
